// File: hw/rtl/skh_pkg.sv
// Shared types and constants for the sorted key histogram table.
// Used by the channel interfaces and the core; depends on nothing.
package skh_pkg;

   localparam logic [11:0] LOW_KEY_RST = 12'd3000;
   localparam logic [31:0] CNT_SAT     = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      REQ_INSERT  = 3'd0,
      REQ_LOOKUP  = 3'd1,
      REQ_READ    = 3'd2,
      REQ_LONGEST = 3'd3,
      REQ_CLOSE   = 3'd4
   } req_kind_type;

   typedef enum logic [2:0] {
      STS_OK        = 3'd0,
      STS_CLOSED    = 3'd1,
      STS_FULL      = 3'd2,
      STS_BAD_AUTH  = 3'd3,
      STS_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPD_RD,
      ST_UPD_WR,
      ST_NEW,
      ST_CLR,
      ST_SHF_RD,
      ST_SHF_WR,
      ST_MAP_RD,
      ST_ENT_RD,
      ST_ENT_CAP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [11:0] year;
      logic [7:0]  authors;
      logic [5:0]  entry_index;
      logic [5:0]  author_bin;
   } skh_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [6:0]  year_count;
      logic [11:0] low_year;
      logic [11:0] high_year;
      logic [31:0] publications;
      logic [11:0] entry_year;
      logic [6:0]  entry_max_authors;
      logic [31:0] bin_count;
      logic [11:0] longest_year;
      logic [6:0]  longest_authors;
   } skh_rsp_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == CNT_SAT) ? v : v + 32'd1;
   endfunction

endpackage

// File: hw/rtl/skh_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on skh_pkg for the payload structs.
interface skh_req_if import skh_pkg::*; ();
   logic        valid;
   logic        ready;
   skh_req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface skh_rsp_if import skh_pkg::*; ();
   logic        valid;
   logic        ready;
   skh_rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/sorted_key_histogram_table_core.sv
// Sorted key histogram table core: one sequencer over per-slot memories.
// Depends on skh_pkg and the channel interfaces in skh_if.sv.
//
// The core takes one request transaction at a time and returns exactly one
// response transaction for it. Years live in physical slots allocated in
// arrival order and never moved; a small order map (position -> slot) keeps
// ascending order, so an insert of a new year shifts only the map, never the
// histograms. Per transaction: lookup, longest query and insert each scan
// the stored years through one compare unit; an insert of a known year adds
// a bin read-modify-write; an insert of a new year adds a pass that clears
// the new histogram and a shift of the order map for the years above it; a
// read entry reads the order map, then the slot and its bin, then captures
// them; close and requests rejected at decode go straight to the response.
// Each response then passes through one output register. The core accepts
// the next request while a response still waits in the output register.
// No clearing pass after reset: slot contents are only read below key_count.
module sorted_key_histogram_table_core import skh_pkg::*; #(
   parameter int MAX_YEARS   = 64,
   parameter int MAX_AUTHORS = 64
) (
   input  logic  clock,
   input  logic  reset,
   skh_req_if.sink   req_chan,
   skh_rsp_if.source rsp_chan
);

   localparam int KW = $clog2(MAX_YEARS + 1);
   localparam int SW = $clog2(MAX_YEARS);
   localparam int AW = $clog2(MAX_AUTHORS);
   localparam int PW = $clog2(MAX_AUTHORS + 1);
   localparam int CW = (KW > 6) ? KW : 6;
   localparam int BD = MAX_YEARS << AW;

   // slot memories and the order map
   logic [11:0]   key_mem   [MAX_YEARS];
   logic [31:0]   total_mem [MAX_YEARS];
   logic [PW-1:0] peak_mem  [MAX_YEARS];
   logic [SW-1:0] map_mem   [MAX_YEARS];
   logic [31:0]   bin_mem   [BD];

   state_type state_ff, state_in;

   logic [2:0]    op_ff, op_in;
   logic [11:0]   year_ff, year_in;
   logic [7:0]    auth_ff, auth_in;
   logic [5:0]    idx_ff, idx_in;
   logic [5:0]    bin_ff, bin_in;
   status_type    status_ff, status_in;

   logic [KW-1:0] scan_ff, scan_in;
   logic          chk_vld_ff, chk_vld_in;
   logic [SW-1:0] chk_slot_ff, chk_slot_in;
   logic          hit_ff, hit_in;
   logic [SW-1:0] hit_slot_ff, hit_slot_in;
   logic [31:0]   hit_total_ff, hit_total_in;
   logic [PW-1:0] hit_peak_ff, hit_peak_in;
   logic [KW-1:0] lt_cnt_ff, lt_cnt_in;
   logic [PW-1:0] best_peak_ff, best_peak_in;
   logic [11:0]   best_year_ff, best_year_in;
   logic [KW-1:0] ptr_ff, ptr_in;
   logic [AW-1:0] clr_ff, clr_in;

   logic [31:0]   pubs_ff, pubs_in;
   logic [11:0]   eyear_ff, eyear_in;
   logic [PW-1:0] epeak_ff, epeak_in;
   logic [31:0]   bcount_ff, bcount_in;
   logic [11:0]   lyear_ff, lyear_in;
   logic [PW-1:0] lauth_ff, lauth_in;

   logic [KW-1:0] key_count_ff, key_count_in;
   logic [11:0]   low_ff, low_in;
   logic [11:0]   high_ff, high_in;
   logic          closed_ff, closed_in;

   logic          rsp_valid_ff, rsp_valid_in;
   skh_rsp_type   rsp_ff, rsp_in;

   // memory ports
   logic          slot_we;
   logic [SW-1:0] slot_waddr, slot_raddr;
   logic [11:0]   key_wd;
   logic [31:0]   total_wd;
   logic [PW-1:0] peak_wd;
   logic          map_we;
   logic [SW-1:0] map_waddr, map_raddr, map_wd;
   logic          bin_we;
   logic [SW+AW-1:0] bin_waddr, bin_raddr;
   logic [31:0]   bin_wd;

   logic [11:0]   key_rd_ff;
   logic [31:0]   total_rd_ff;
   logic [PW-1:0] peak_rd_ff;
   logic [SW-1:0] map_rd_ff;
   logic [31:0]   bin_rd_ff;

   // decode helpers
   logic          req_fire;
   logic          auth_ok;
   logic          read_ok;
   logic          scan_more;
   logic          scan_done;
   logic          table_full;
   logic          rsp_free;
   logic [AW-1:0] auth_bin;
   logic [PW-1:0] auth_pk;
   logic [SW-1:0] new_slot;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire   = req_chan.valid && req_chan.ready;
   assign auth_ok    = (req_chan.payload.authors != 8'd0)
                    && (32'(req_chan.payload.authors) <= MAX_AUTHORS);
   assign read_ok    = (CW'(req_chan.payload.entry_index) < CW'(key_count_ff))
                    && (32'(req_chan.payload.author_bin) < MAX_AUTHORS);
   assign scan_more  = (scan_ff < key_count_ff);
   assign scan_done  = !scan_more && !chk_vld_ff;
   assign table_full = (key_count_ff == KW'(MAX_YEARS));
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;
   assign auth_bin   = AW'(auth_ff - 8'd1);
   assign auth_pk    = PW'(auth_ff);
   assign new_slot   = key_count_ff[SW-1:0];

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_chan.payload.req_type)
                  REQ_INSERT: begin
                     state_in = (closed_ff || !auth_ok) ? ST_DONE : ST_SCAN;
                  end
                  REQ_LOOKUP, REQ_LONGEST: state_in = ST_SCAN;
                  REQ_READ: state_in = read_ok ? ST_MAP_RD : ST_DONE;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               if (op_ff == REQ_INSERT) begin
                  priority if (hit_ff) state_in = ST_UPD_RD;
                  else if (table_full) state_in = ST_DONE;
                  else state_in = ST_NEW;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_UPD_RD: state_in = ST_UPD_WR;
         ST_UPD_WR: state_in = ST_DONE;
         ST_NEW:    state_in = ST_CLR;
         ST_CLR: begin
            if (32'(clr_ff) == MAX_AUTHORS - 1) state_in = ST_SHF_RD;
         end
         ST_SHF_RD: state_in = (ptr_ff > lt_cnt_ff) ? ST_SHF_WR : ST_DONE;
         ST_SHF_WR: state_in = ST_SHF_RD;
         ST_MAP_RD: state_in = ST_ENT_RD;
         ST_ENT_RD: state_in = ST_ENT_CAP;
         ST_ENT_CAP: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      op_in        = op_ff;
      year_in      = year_ff;
      auth_in      = auth_ff;
      idx_in       = idx_ff;
      bin_in       = bin_ff;
      status_in    = status_ff;
      scan_in      = scan_ff;
      chk_vld_in   = 1'b0;
      chk_slot_in  = chk_slot_ff;
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      hit_total_in = hit_total_ff;
      hit_peak_in  = hit_peak_ff;
      lt_cnt_in    = lt_cnt_ff;
      best_peak_in = best_peak_ff;
      best_year_in = best_year_ff;
      ptr_in       = ptr_ff;
      clr_in       = clr_ff;
      pubs_in      = pubs_ff;
      eyear_in     = eyear_ff;
      epeak_in     = epeak_ff;
      bcount_in    = bcount_ff;
      lyear_in     = lyear_ff;
      lauth_in     = lauth_ff;
      key_count_in = key_count_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      closed_in    = closed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in       = rsp_ff;

      slot_we    = 1'b0;
      slot_waddr = hit_slot_ff;
      slot_raddr = scan_ff[SW-1:0];
      key_wd     = year_ff;
      total_wd   = sat_inc(hit_total_ff);
      peak_wd    = (auth_pk > hit_peak_ff) ? auth_pk : hit_peak_ff;
      map_we     = 1'b0;
      map_waddr  = ptr_ff[SW-1:0];
      map_raddr  = SW'(ptr_ff - KW'(1));
      map_wd     = map_rd_ff;
      bin_we     = 1'b0;
      bin_waddr  = {hit_slot_ff, auth_bin};
      bin_raddr  = {hit_slot_ff, auth_bin};
      bin_wd     = sat_inc(bin_rd_ff);

      unique case (state_ff)
         ST_IDLE: begin
            // latch the transaction and clear per-transaction state
            if (req_fire) begin
               op_in        = req_chan.payload.req_type;
               year_in      = req_chan.payload.year;
               auth_in      = req_chan.payload.authors;
               idx_in       = req_chan.payload.entry_index;
               bin_in       = req_chan.payload.author_bin;
               status_in    = STS_OK;
               scan_in      = '0;
               hit_in       = 1'b0;
               lt_cnt_in    = '0;
               best_peak_in = '0;
               best_year_in = '0;
               pubs_in      = '0;
               eyear_in     = '0;
               epeak_in     = '0;
               bcount_in    = '0;
               lyear_in     = '0;
               lauth_in     = '0;
               unique case (req_chan.payload.req_type)
                  REQ_INSERT: begin
                     priority if (closed_ff) status_in = STS_CLOSED;
                     else if (!auth_ok) status_in = STS_BAD_AUTH;
                     else status_in = STS_OK;
                  end
                  REQ_LOOKUP, REQ_LONGEST: status_in = STS_OK;
                  REQ_READ: status_in = read_ok ? STS_OK : STS_NOT_FOUND;
                  REQ_CLOSE: begin
                     status_in = closed_ff ? STS_CLOSED : STS_OK;
                     closed_in = 1'b1;
                  end
                  default: status_in = STS_NOT_FOUND;
               endcase
            end
         end
         ST_SCAN: begin
            // issue one slot read per cycle, check the previous one
            if (scan_more) begin
               chk_vld_in  = 1'b1;
               chk_slot_in = scan_ff[SW-1:0];
               scan_in     = scan_ff + KW'(1);
            end
            if (chk_vld_ff) begin
               if (key_rd_ff == year_ff) begin
                  hit_in       = 1'b1;
                  hit_slot_in  = chk_slot_ff;
                  hit_total_in = total_rd_ff;
                  hit_peak_in  = peak_rd_ff;
               end
               if (key_rd_ff < year_ff) lt_cnt_in = lt_cnt_ff + KW'(1);
               if ((peak_rd_ff > best_peak_ff)
                   || ((peak_rd_ff == best_peak_ff) && (key_rd_ff < best_year_ff))) begin
                  best_peak_in = peak_rd_ff;
                  best_year_in = key_rd_ff;
               end
            end
            if (scan_done) begin
               if (op_ff == REQ_LOOKUP) begin
                  status_in = hit_ff ? STS_OK : STS_NOT_FOUND;
                  pubs_in   = hit_ff ? hit_total_ff : 32'd0;
               end else if (op_ff == REQ_LONGEST) begin
                  lyear_in = best_year_ff;
                  lauth_in = best_peak_ff;
               end else if (!hit_ff && table_full) begin
                  status_in = STS_FULL;
               end
            end
         end
         ST_UPD_RD: begin
            // bin read issued by default address
         end
         ST_UPD_WR: begin
            slot_we = 1'b1;
            key_wd  = year_ff;
            bin_we  = 1'b1;
         end
         ST_NEW: begin
            slot_we    = 1'b1;
            slot_waddr = new_slot;
            total_wd   = 32'd1;
            peak_wd    = auth_pk;
            clr_in     = '0;
            ptr_in     = key_count_ff;
            if (key_count_ff == '0) begin
               low_in  = year_ff;
               high_in = year_ff;
            end else begin
               if (year_ff < low_ff)  low_in  = year_ff;
               if (year_ff > high_ff) high_in = year_ff;
            end
         end
         ST_CLR: begin
            // sweep the new slot's histogram, seed the inserted bin
            bin_we    = 1'b1;
            bin_waddr = {new_slot, clr_ff};
            bin_wd    = (clr_ff == auth_bin) ? 32'd1 : 32'd0;
            clr_in    = clr_ff + AW'(1);
         end
         ST_SHF_RD: begin
            if (ptr_ff <= lt_cnt_ff) begin
               map_we       = 1'b1;
               map_waddr    = lt_cnt_ff[SW-1:0];
               map_wd       = new_slot;
               key_count_in = key_count_ff + KW'(1);
            end
         end
         ST_SHF_WR: begin
            map_we = 1'b1;
            ptr_in = ptr_ff - KW'(1);
         end
         ST_MAP_RD: begin
            map_raddr = SW'(idx_ff);
         end
         ST_ENT_RD: begin
            slot_raddr = map_rd_ff;
            bin_raddr  = {map_rd_ff, AW'(bin_ff)};
         end
         ST_ENT_CAP: begin
            pubs_in   = total_rd_ff;
            eyear_in  = key_rd_ff;
            epeak_in  = peak_rd_ff;
            bcount_in = bin_rd_ff;
         end
         ST_DONE: begin
            // hand the result to the output register once it is free
            if (rsp_free) begin
               rsp_valid_in              = 1'b1;
               rsp_in.status             = status_ff;
               rsp_in.year_count         = 7'(key_count_ff);
               rsp_in.low_year           = low_ff;
               rsp_in.high_year          = high_ff;
               rsp_in.publications       = pubs_ff;
               rsp_in.entry_year         = eyear_ff;
               rsp_in.entry_max_authors  = 7'(epeak_ff);
               rsp_in.bin_count          = bcount_ff;
               rsp_in.longest_year       = lyear_ff;
               rsp_in.longest_authors    = 7'(lauth_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_vld_ff   <= 1'b0;
         scan_ff      <= '0;
         key_count_ff <= '0;
         low_ff       <= LOW_KEY_RST;
         high_ff      <= '0;
         closed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_vld_ff   <= chk_vld_in;
         scan_ff      <= scan_in;
         key_count_ff <= key_count_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         closed_ff    <= closed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      year_ff      <= year_in;
      auth_ff      <= auth_in;
      idx_ff       <= idx_in;
      bin_ff       <= bin_in;
      status_ff    <= status_in;
      chk_slot_ff  <= chk_slot_in;
      hit_ff       <= hit_in;
      hit_slot_ff  <= hit_slot_in;
      hit_total_ff <= hit_total_in;
      hit_peak_ff  <= hit_peak_in;
      lt_cnt_ff    <= lt_cnt_in;
      best_peak_ff <= best_peak_in;
      best_year_ff <= best_year_in;
      ptr_ff       <= ptr_in;
      clr_ff       <= clr_in;
      pubs_ff      <= pubs_in;
      eyear_ff     <= eyear_in;
      epeak_ff     <= epeak_in;
      bcount_ff    <= bcount_in;
      lyear_ff     <= lyear_in;
      lauth_ff     <= lauth_in;
      rsp_ff       <= rsp_in;
   end

   // slot memories
   always_ff @(posedge clock) begin
      if (slot_we) begin
         key_mem[slot_waddr]   <= key_wd;
         total_mem[slot_waddr] <= total_wd;
         peak_mem[slot_waddr]  <= peak_wd;
      end
      key_rd_ff   <= key_mem[slot_raddr];
      total_rd_ff <= total_mem[slot_raddr];
      peak_rd_ff  <= peak_mem[slot_raddr];
   end

   // order map
   always_ff @(posedge clock) begin
      if (map_we) map_mem[map_waddr] <= map_wd;
      map_rd_ff <= map_mem[map_raddr];
   end

   // histogram memory
   always_ff @(posedge clock) begin
      if (bin_we) bin_mem[bin_waddr] <= bin_wd;
      bin_rd_ff <= bin_mem[bin_raddr];
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      key_count_ff <= KW'(MAX_YEARS))
      else $error("key count beyond table depth");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      scan_ff <= key_count_ff)
      else $error("scan pointer beyond key count");

   a_range_order: assert property (@(posedge clock) disable iff (reset)
      (key_count_ff != '0) |-> (low_ff <= high_ff))
      else $error("min year above max year");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((key_count_ff == $past(key_count_ff))
             || (key_count_ff == $past(key_count_ff) + KW'(1))))
      else $error("key count moved by more than one");

   a_closed_sticky: assert property (@(posedge clock) disable iff (reset)
      closed_ff |=> closed_ff)
      else $error("close flag dropped");

endmodule
